### hw/rtl/fbba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbba_pkg
// Shared types, widths, register codes and the band edge table of the
// FFT bin band averager.
// ----------------------------------------------------------------------------
package fbba_pkg;

    // Fixed geometry
    localparam int NUM_BANDS     = 48;
    localparam int MAG_WIDTH_DEF = 24;
    localparam int MAG_FIELD_W   = 24;
    localparam int BIN_W         = 8;
    localparam int BAND_W        = 6;
    localparam int SUM_W         = 30;
    localparam int BOOST_W       = 9;
    localparam int SHIFT_W       = 4;
    localparam int HEIGHT_W      = 15;
    localparam int COUNT_W       = 5;
    localparam int PROD_W        = SUM_W + BOOST_W;
    localparam int RECIP_W       = 31;
    localparam int RECIP_BASE    = SUM_W;
    localparam int RSH_W         = 3;
    localparam int FRAC_IN_W     = COUNT_W + BOOST_W;
    localparam int IDATA_W       = 24;
    localparam int ODATA_W       = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 15;

    localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOOST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOOST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIM  = 3'd4;

    // Register reset values
    localparam logic [BOOST_W-1:0]  LOW_BOOST_RST   = 9'd205;
    localparam logic [BOOST_W-1:0]  HIGH_BOOST_RST  = 9'd256;
    localparam logic [BAND_W-1:0]   LOW_COUNT_RST   = 6'd12;
    localparam logic [SHIFT_W-1:0]  SCALE_SHIFT_RST = 4'd6;
    localparam logic [HEIGHT_W-1:0] HEIGHT_LIM_RST  = 15'd20480;

    // Inclusive bin ranges of the bands
    localparam logic [BIN_W-1:0] BAND_LO [NUM_BANDS] = '{
        8'd2,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
        8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,
        8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,
        8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd32,  8'd34,
        8'd36,  8'd40,  8'd44,  8'd48,  8'd54,  8'd60,  8'd66,  8'd74,
        8'd82,  8'd92,  8'd102, 8'd115, 8'd128, 8'd146, 8'd164, 8'd182
    };
    localparam logic [BIN_W-1:0] BAND_HI [NUM_BANDS] = '{
        8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
        8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,  8'd17,
        8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,  8'd25,
        8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd32,  8'd34,  8'd36,
        8'd40,  8'd44,  8'd48,  8'd54,  8'd60,  8'd66,  8'd74,  8'd82,
        8'd92,  8'd102, 8'd115, 8'd128, 8'd146, 8'd164, 8'd182, 8'd200
    };

    // Low edge of a band; a band past the end never matches
    function automatic logic [BIN_W-1:0] band_lo(input logic [BAND_W-1:0] band);
        logic [BIN_W-1:0] lo;
        lo = BIN_MAX;
        if (band < BAND_W'(NUM_BANDS))
        begin
            lo = BAND_LO[band];
        end
        return lo;
    endfunction

    // High edge of a band; a band past the end never matches
    function automatic logic [BIN_W-1:0] band_hi(input logic [BAND_W-1:0] band);
        logic [BIN_W-1:0] hi;
        hi = '0;
        if (band < BAND_W'(NUM_BANDS))
        begin
            hi = BAND_HI[band];
        end
        return hi;
    endfunction

    // Reciprocal of a band's bin count: ceil(2^(RECIP_BASE + shift) / count),
    // exact for any dividend below 2^SUM_W
    function automatic logic [RECIP_W-1:0] recip_of(input logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        unique case (count)
            5'd1:    m = 31'd1073741824;
            5'd2:    m = 31'd1073741824;
            5'd3:    m = 31'd1431655766;
            5'd5:    m = 31'd1717986919;
            5'd7:    m = 31'd1227133514;
            5'd9:    m = 31'd1908874354;
            5'd11:   m = 31'd1561806290;
            5'd14:   m = 31'd1227133514;
            5'd19:   m = 31'd1808407283;
            default: m = '0;
        endcase
        return m;
    endfunction

    // Extra right shift that goes with the reciprocal: ceil(log2(count))
    function automatic logic [RSH_W-1:0] recip_shift_of(input logic [COUNT_W-1:0] count);
        logic [RSH_W-1:0] sh;
        unique case (count)
            5'd1:    sh = 3'd0;
            5'd2:    sh = 3'd1;
            5'd3:    sh = 3'd2;
            5'd5:    sh = 3'd3;
            5'd7:    sh = 3'd3;
            5'd9:    sh = 3'd4;
            5'd11:   sh = 3'd4;
            5'd14:   sh = 3'd4;
            5'd19:   sh = 3'd5;
            default: sh = '0;
        endcase
        return sh;
    endfunction

    // Configuration register set
    typedef struct packed {
        logic [BOOST_W-1:0]  low_band_boost;
        logic [BOOST_W-1:0]  high_band_boost;
        logic [BAND_W-1:0]   low_band_count;
        logic [SHIFT_W-1:0]  scale_shift;
        logic [HEIGHT_W-1:0] height_limit;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic quo_load;
        logic rem_load;
        logic scale_load;
        logic frac_load;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic band_close;
        logic out_busy;
    } status_t;

endpackage

### hw/rtl/fft_bin_band_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_bin_band_averager
// Sums FFT magnitude bins into 48 fixed bands and emits each band's boosted,
// scaled and clamped average in Q7.8 when its last bin arrives.
//
// Channel   Dir   Handshake          Contents
// s_*       in    tvalid / tready    tdata: bin_magnitude[23:0]; tlast: frame_end
// m_*       out   tvalid / tready    tdata: band_index[5:0], band_height[20:6]
//                                    tlast: last_band
// cfg_*     in    cfg_we             cfg_index selects register, cfg_data value
//
// A bin that closes no band is only accepted. A bin that closes a band runs
// through accept, the sum's quotient by the bin count (reciprocal multiply),
// the remainder and the boosted quotient, the boosted remainder, its quotient
// by the bin count, and one output load that adds, shifts and clamps.
// The output register lets the next bin enter while a result waits; the
// output load waits while the previous result is not taken.
// Reset clears the frame state, the output valid and the registers to their
// defaults at once.
// ----------------------------------------------------------------------------
module fft_bin_band_averager
#(
    parameter int MAG_WIDTH = fbba_pkg::MAG_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fbba_pkg::IDATA_W-1:0]      s_tdata,   // bin_magnitude[23:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fbba_pkg::ODATA_W-1:0]      m_tdata,   // band_index[5:0], band_height[20:6]
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [fbba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbba_pkg::CFG_DATA_W-1:0]   cfg_data
);

    fbba_pkg::cfg_t    cfg_reg;
    fbba_pkg::cmd_t    cmd;
    fbba_pkg::status_t status;

    logic [fbba_pkg::BAND_W-1:0]   band_index;
    logic [fbba_pkg::HEIGHT_W-1:0] band_height;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_band_boost  <= fbba_pkg::LOW_BOOST_RST;
            cfg_reg.high_band_boost <= fbba_pkg::HIGH_BOOST_RST;
            cfg_reg.low_band_count  <= fbba_pkg::LOW_COUNT_RST;
            cfg_reg.scale_shift     <= fbba_pkg::SCALE_SHIFT_RST;
            cfg_reg.height_limit    <= fbba_pkg::HEIGHT_LIM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fbba_pkg::CFG_LOW_BOOST:
                    cfg_reg.low_band_boost  <= cfg_data[fbba_pkg::BOOST_W-1:0];
                fbba_pkg::CFG_HIGH_BOOST:
                    cfg_reg.high_band_boost <= cfg_data[fbba_pkg::BOOST_W-1:0];
                fbba_pkg::CFG_LOW_COUNT:
                    cfg_reg.low_band_count  <= cfg_data[fbba_pkg::BAND_W-1:0];
                fbba_pkg::CFG_SCALE_SHIFT:
                    cfg_reg.scale_shift     <= cfg_data[fbba_pkg::SHIFT_W-1:0];
                fbba_pkg::CFG_HEIGHT_LIM:
                    cfg_reg.height_limit    <= cfg_data[fbba_pkg::HEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    fbba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fbba_dp #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg_reg),
        .bin_magnitude (s_tdata[fbba_pkg::MAG_FIELD_W-1:0]),
        .frame_end     (s_tlast),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .band_index    (band_index),
        .band_height   (band_height),
        .last_band     (m_tlast)
    );

    // Pack the result, zero filled to whole bytes
    assign m_tdata = {{(fbba_pkg::ODATA_W - fbba_pkg::BAND_W - fbba_pkg::HEIGHT_W){1'b0}},
                      band_height, band_index};

endmodule

### hw/rtl/fbba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbba_ctrl
// Sequencer of the band averager: takes bins, and for a closing band runs
// the reciprocal divide by the bin count, the boost and the output load.
// ----------------------------------------------------------------------------
module fbba_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fbba_pkg::status_t status,
    output fbba_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUO,
        ST_REM,
        ST_SCALE,
        ST_FRAC,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Decode commands and next state
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.band_close)
                    begin
                        state_next = ST_QUO;
                    end
                end
            end
            ST_QUO:
            begin
                cmd.quo_load = 1'b1;
                state_next   = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem_load = 1'b1;
                state_next   = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_load = 1'b1;
                state_next     = ST_FRAC;
            end
            ST_FRAC:
            begin
                cmd.frac_load = 1'b1;
                state_next    = ST_FIN;
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/fbba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbba_dp
// Datapath of the band averager: bin counter, the two open band sums,
// reciprocal divide by the bin count, boost, scale, clamp and output register.
// ----------------------------------------------------------------------------
module fbba_dp
#(
    parameter int MAG_WIDTH = fbba_pkg::MAG_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fbba_pkg::cmd_t                    cmd,
    output fbba_pkg::status_t                 status,
    input  fbba_pkg::cfg_t                    cfg,
    input  logic [fbba_pkg::MAG_FIELD_W-1:0]  bin_magnitude,
    input  logic                              frame_end,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [fbba_pkg::BAND_W-1:0]       band_index,
    output logic [fbba_pkg::HEIGHT_W-1:0]     band_height,
    output logic                              last_band
);

    localparam int MW  = fbba_pkg::MAG_FIELD_W;
    localparam int BW  = fbba_pkg::BAND_W;
    localparam int NW  = fbba_pkg::BIN_W;
    localparam int SW  = fbba_pkg::SUM_W;
    localparam int PW  = fbba_pkg::PROD_W;
    localparam int CW  = fbba_pkg::COUNT_W;
    localparam int HW  = fbba_pkg::HEIGHT_W;
    localparam int GW  = fbba_pkg::BOOST_W;
    localparam int RW  = fbba_pkg::RECIP_W;
    localparam int LW  = fbba_pkg::RSH_W;
    localparam int YW  = fbba_pkg::FRAC_IN_W;
    localparam int QW  = SW + RW;
    localparam int FW  = YW + RW;
    localparam int KW  = 2 * CW;

    // Frame state
    logic [NW-1:0] bin_counter_reg;
    logic [SW-1:0] sum0_reg;
    logic [SW-1:0] sum1_reg;
    logic [BW-1:0] cur_band_reg;

    // Closing band and its height pipeline
    logic [BW-1:0] close_band_reg;
    logic [SW-1:0] close_sum_reg;
    logic [SW-1:0] quo_reg;
    logic [CW-1:0] rem_reg;
    logic [PW-1:0] whole_reg;
    logic [YW-1:0] scaled_rem_reg;
    logic [GW-1:0] frac_reg;

    // Output register
    logic          out_valid_reg;
    logic [BW-1:0] out_index_reg;
    logic [HW-1:0] out_height_reg;
    logic          out_last_reg;

    logic [MW-1:0] mag;
    logic [BW-1:0] next_band;
    logic          in0;
    logic          in1;
    logic          close;
    logic [SW-1:0] sum0_add;
    logic [SW-1:0] sum1_add;
    logic [NW-1:0] lo_sel;
    logic [NW-1:0] hi_sel;
    logic [NW-1:0] bin_span;
    logic [CW-1:0] bin_count;
    logic [GW-1:0] boost;
    logic [RW-1:0] recip;
    logic [LW-1:0] recip_sh;
    logic [QW-1:0] quo_prod;
    logic [QW-1:0] quo_full;
    logic [KW-1:0] quo_count_low;
    logic [FW-1:0] frac_prod;
    logic [FW-1:0] frac_full;
    logic [PW-1:0] total;
    logic [PW-1:0] scaled;
    logic [HW-1:0] clamped;

    // Keep the low MAG_WIDTH bits of the magnitude
    always_comb
    begin
        for (int i = 0; i < MW; i++)
        begin
            mag[i] = (i < MAG_WIDTH) ? bin_magnitude[i] : 1'b0;
        end
    end

    // Band membership of the current bin
    assign next_band = cur_band_reg + BW'(1);
    assign in0 = (bin_counter_reg >= fbba_pkg::band_lo(cur_band_reg))
              && (bin_counter_reg <= fbba_pkg::band_hi(cur_band_reg));
    assign in1 = (bin_counter_reg >= fbba_pkg::band_lo(next_band))
              && (bin_counter_reg <= fbba_pkg::band_hi(next_band));
    assign close = (cur_band_reg < BW'(fbba_pkg::NUM_BANDS))
                && (bin_counter_reg == fbba_pkg::band_hi(cur_band_reg));
    assign sum0_add = in0 ? (sum0_reg + SW'(mag)) : sum0_reg;
    assign sum1_add = in1 ? (sum1_reg + SW'(mag)) : sum1_reg;

    // Advance the frame state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_counter_reg <= '0;
            sum0_reg        <= '0;
            sum1_reg        <= '0;
            cur_band_reg    <= '0;
        end
        else if (cmd.accept)
        begin
            if (frame_end)
            begin
                bin_counter_reg <= '0;
                sum0_reg        <= '0;
                sum1_reg        <= '0;
                cur_band_reg    <= '0;
            end
            else
            begin
                if (bin_counter_reg != fbba_pkg::BIN_MAX)
                begin
                    bin_counter_reg <= bin_counter_reg + NW'(1);
                end
                if (close)
                begin
                    sum0_reg     <= sum1_add;
                    sum1_reg     <= '0;
                    cur_band_reg <= next_band;
                end
                else
                begin
                    sum0_reg <= sum0_add;
                    sum1_reg <= sum1_add;
                end
            end
        end
    end

    // Capture the closing band
    always_ff @(posedge clk)
    begin
        if (cmd.accept && close)
        begin
            close_band_reg <= cur_band_reg;
            close_sum_reg  <= sum0_add;
        end
    end

    // Boost, bin count and its reciprocal for the closing band
    assign lo_sel    = fbba_pkg::band_lo(close_band_reg);
    assign hi_sel    = fbba_pkg::band_hi(close_band_reg);
    assign bin_span  = hi_sel - lo_sel + NW'(1);
    assign bin_count = bin_span[CW-1:0];
    assign boost     = (close_band_reg < cfg.low_band_count) ? cfg.low_band_boost
                                                             : cfg.high_band_boost;
    assign recip     = fbba_pkg::recip_of(bin_count);
    assign recip_sh  = fbba_pkg::recip_shift_of(bin_count);

    // Quotient of the band sum by the bin count
    assign quo_prod = QW'(close_sum_reg) * QW'(recip);
    assign quo_full = (quo_prod >> fbba_pkg::RECIP_BASE) >> recip_sh;

    // Remainder is below the bin count, so its low bits are enough
    assign quo_count_low = KW'(quo_reg[CW-1:0]) * KW'(bin_count);

    // Boosted remainder divided by the bin count
    assign frac_prod = FW'(scaled_rem_reg) * FW'(recip);
    assign frac_full = (frac_prod >> fbba_pkg::RECIP_BASE) >> recip_sh;

    // Add both parts, scale and clamp
    assign total   = whole_reg + PW'(frac_reg);
    assign scaled  = total >> cfg.scale_shift;
    assign clamped = (scaled > PW'(cfg.height_limit)) ? cfg.height_limit : scaled[HW-1:0];

    // Step through quotient, remainder and boosted quotient, boosted remainder and its share
    always_ff @(posedge clk)
    begin
        if (cmd.quo_load)
        begin
            quo_reg <= quo_full[SW-1:0];
        end
        if (cmd.rem_load)
        begin
            rem_reg   <= close_sum_reg[CW-1:0] - quo_count_low[CW-1:0];
            whole_reg <= PW'(quo_reg) * PW'(boost);
        end
        if (cmd.scale_load)
        begin
            scaled_rem_reg <= YW'(rem_reg) * YW'(boost);
        end
        if (cmd.frac_load)
        begin
            frac_reg <= frac_full[GW-1:0];
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index_reg  <= close_band_reg;
            out_height_reg <= clamped;
            out_last_reg   <= (close_band_reg == BW'(fbba_pkg::NUM_BANDS - 1));
        end
    end

    assign out_valid   = out_valid_reg;
    assign band_index  = out_index_reg;
    assign band_height = out_height_reg;
    assign last_band   = out_last_reg;

    assign status.band_close = close;
    assign status.out_busy   = out_valid_reg && !out_ready;

endmodule
